[rtl/fme_pkg.sv]
`timescale 1ns / 1ps

package fme_pkg;

  // Region codes reported with each grade.
  localparam logic [1:0] REG_OUTSIDE = 2'd0;
  localparam logic [1:0] REG_RISING  = 2'd1;
  localparam logic [1:0] REG_PLATEAU = 2'd2;
  localparam logic [1:0] REG_FALLING = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] CFG_SHAPE_MODE = 3'd0;
  localparam logic [2:0] CFG_POINT_A    = 3'd1;
  localparam logic [2:0] CFG_POINT_B    = 3'd2;
  localparam logic [2:0] CFG_POINT_C    = 3'd3;
  localparam logic [2:0] CFG_POINT_D    = 3'd4;

  // Reset values of the configuration registers.
  localparam logic        RST_SHAPE_MODE = 1'b1;
  localparam logic [31:0] RST_POINT_A    = 32'd0;
  localparam logic [31:0] RST_POINT_B    = 32'd65536;
  localparam logic [31:0] RST_POINT_C    = 32'd131072;
  localparam logic [31:0] RST_POINT_D    = 32'd196608;

  // Width of the divider operands. A difference of two signed 32-bit values
  // that is known to be positive always fits in 32 unsigned bits.
  localparam int OPND_W = 32;

  // Control that travels with each word down the pipeline.
  typedef struct packed {
    logic       valid;
    logic [1:0] region;
  } ctl_t;

endpackage

[rtl/fme_divider.sv]
`timescale 1ns / 1ps

// Pipelined restoring divider for num <= den: one quotient bit per stage.
module fme_divider #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  fme_pkg::ctl_t                 in_ctl,
  input  logic [fme_pkg::OPND_W-1:0]    in_num,
  input  logic [fme_pkg::OPND_W-1:0]    in_den,
  output fme_pkg::ctl_t                 out_ctl,
  output logic [FRAC_BITS:0]            out_quo
);

  localparam int LAST = FRAC_BITS;
  localparam int W    = fme_pkg::OPND_W;

  fme_pkg::ctl_t       ctl_r [0:LAST];
  logic [W-1:0]        rem_r [0:LAST];
  logic [W-1:0]        den_r [0:LAST];
  logic [FRAC_BITS:0]  quo_r [0:LAST];

  logic [W:0]          dbl   [1:LAST];
  logic                take  [1:LAST];

  always_comb begin
    for (int k = 1; k <= LAST; k++) begin
      dbl[k]  = {rem_r[k-1], 1'b0};
      take[k] = dbl[k] >= {1'b0, den_r[k-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= LAST; k++) begin
        ctl_r[k] <= '0;
      end
    end else if (adv) begin
      ctl_r[0] <= in_ctl;
      for (int k = 1; k <= LAST; k++) begin
        ctl_r[k] <= ctl_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // The integer bit: set only when num equals den.
      if (in_num >= in_den) begin
        rem_r[0] <= in_num - in_den;
        quo_r[0] <= {1'b1, {FRAC_BITS{1'b0}}};
      end else begin
        rem_r[0] <= in_num;
        quo_r[0] <= '0;
      end
      den_r[0] <= in_den;
      for (int k = 1; k <= LAST; k++) begin
        if (take[k]) begin
          rem_r[k] <= W'(dbl[k] - {1'b0, den_r[k-1]});
        end else begin
          rem_r[k] <= dbl[k][W-1:0];
        end
        den_r[k] <= den_r[k-1];
        quo_r[k] <= quo_r[k-1] | ((FRAC_BITS + 1)'(take[k]) << (LAST - k));
      end
    end
  end

  assign out_ctl = ctl_r[LAST];
  assign out_quo = quo_r[LAST];

`ifndef SYNTHESIS
  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !ctl_r[0].valid && !ctl_r[LAST].valid)
    else $error("divider holds a valid word after reset");

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_r[LAST].valid &&
    (ctl_r[LAST].region == fme_pkg::REG_RISING ||
     ctl_r[LAST].region == fme_pkg::REG_FALLING)
    |-> rem_r[LAST] < den_r[LAST])
    else $error("divider remainder not below divisor");
`endif

endmodule

[rtl/fuzzy_membership_evaluator.sv]
`timescale 1ns / 1ps

// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    in_sample_x (signed Q16.16)
// out      output     out_valid / out_ready  out_grade (Q1.FRAC_BITS), out_region
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One word is accepted every cycle while the output is not stalled; the divider
// resolves one quotient bit per pipeline stage after one stage of compares and
// subtracts.
// Reset (rst_n, synchronous, active low) empties the pipeline and loads the
// default trapezoid 0, 1, 2, 3. A stall on the output freezes every stage
// at once, so in_ready falls in the same cycle and no word is lost or repeated.
// Configuration writes are always ready and take effect on the next cycle.
module fuzzy_membership_evaluator #(
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,

  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [31:0]           in_sample_x,

  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [FRAC_BITS:0]           out_grade,
  output logic [1:0]                   out_region,

  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [2:0]                   cfg_index,
  input  logic [31:0]                  cfg_data
);

  localparam int W = fme_pkg::OPND_W;
  localparam logic [FRAC_BITS:0] GradeOne = {1'b1, {FRAC_BITS{1'b0}}};

  // Configuration registers.
  logic        shape_mode_r;
  logic [31:0] point_a_r;
  logic [31:0] point_b_r;
  logic [31:0] point_c_r;
  logic [31:0] point_d_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shape_mode_r <= fme_pkg::RST_SHAPE_MODE;
      point_a_r    <= fme_pkg::RST_POINT_A;
      point_b_r    <= fme_pkg::RST_POINT_B;
      point_c_r    <= fme_pkg::RST_POINT_C;
      point_d_r    <= fme_pkg::RST_POINT_D;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fme_pkg::CFG_SHAPE_MODE: shape_mode_r <= cfg_data[0];
        fme_pkg::CFG_POINT_A:    point_a_r    <= cfg_data;
        fme_pkg::CFG_POINT_B:    point_b_r    <= cfg_data;
        fme_pkg::CFG_POINT_C:    point_c_r    <= cfg_data;
        fme_pkg::CFG_POINT_D:    point_d_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // The whole pipeline moves together; it advances unless the final
  // result is held by the consumer.
  fme_pkg::ctl_t div_ctl;
  logic [FRAC_BITS:0] div_quo;
  logic adv;

  assign adv      = !div_ctl.valid || out_ready;
  assign in_ready = adv;

  // Front stage: classify the sample and pick the edge's operands.
  // Everything is compared at 33 bits so that no difference can wrap.
  logic signed [32:0] x_ext, a_ext, b_ext, c_ext, d_ext, right_ext;
  logic signed [32:0] diff_num, diff_den;
  logic [1:0]         region_nxt;

  assign x_ext     = {in_sample_x[31], in_sample_x};
  assign a_ext     = {point_a_r[31], point_a_r};
  assign b_ext     = {point_b_r[31], point_b_r};
  assign c_ext     = {point_c_r[31], point_c_r};
  assign d_ext     = {point_d_r[31], point_d_r};
  assign right_ext = shape_mode_r ? d_ext : c_ext;

  always_comb begin
    region_nxt = fme_pkg::REG_OUTSIDE;
    diff_num   = '0;
    diff_den   = 33'sd1;
    if (x_ext <= a_ext || x_ext >= right_ext) begin
      region_nxt = fme_pkg::REG_OUTSIDE;
    end else if (x_ext <= b_ext) begin
      region_nxt = fme_pkg::REG_RISING;
      diff_num   = x_ext - a_ext;
      diff_den   = b_ext - a_ext;
    end else if (shape_mode_r && x_ext <= c_ext) begin
      region_nxt = fme_pkg::REG_PLATEAU;
    end else if (shape_mode_r) begin
      region_nxt = fme_pkg::REG_FALLING;
      diff_num   = d_ext - x_ext;
      diff_den   = d_ext - c_ext;
    end else begin
      region_nxt = fme_pkg::REG_FALLING;
      diff_num   = c_ext - x_ext;
      diff_den   = c_ext - b_ext;
    end
  end

  // On an edge the numerator is positive and never exceeds the divisor,
  // so both fit in 32 unsigned bits and the quotient never tops one.
  fme_pkg::ctl_t front_ctl_r;
  logic [W-1:0]  front_num_r;
  logic [W-1:0]  front_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_ctl_r <= '0;
    end else if (adv) begin
      front_ctl_r.valid  <= in_valid;
      front_ctl_r.region <= region_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      front_num_r <= diff_num[W-1:0];
      front_den_r <= diff_den[W-1:0];
    end
  end

  fme_divider #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_ctl  (front_ctl_r),
    .in_num  (front_num_r),
    .in_den  (front_den_r),
    .out_ctl (div_ctl),
    .out_quo (div_quo)
  );

  // Outside the support the grade is zero and on the plateau it is one;
  // only the rising and falling regions use the quotient.
  always_comb begin
    case (div_ctl.region)
      fme_pkg::REG_OUTSIDE: out_grade = '0;
      fme_pkg::REG_PLATEAU: out_grade = GradeOne;
      default:              out_grade = div_quo;
    endcase
  end

  assign out_valid  = div_ctl.valid;
  assign out_region = div_ctl.region;

`ifndef SYNTHESIS
  a_grade_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_grade <= GradeOne)
    else $error("grade above one");

  a_falling_below_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_region == fme_pkg::REG_FALLING |-> out_grade != GradeOne)
    else $error("falling edge reached a full grade");

  a_triangle_no_plateau: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !shape_mode_r |-> out_region != fme_pkg::REG_PLATEAU)
    else $error("triangle reported a plateau");
`endif

endmodule

[tb/fuzzy_membership_evaluator_tb.sv]
`timescale 1ns / 1ps

// Self-checking bench for the fuzzy membership evaluator. Samples are queued by
// the stimulus process, handed to the block by a clocked driver, and graded by
// a bench-side model the moment the block accepts them. Each returned word is
// then compared field by field with the oldest outstanding grade.
module fuzzy_membership_evaluator_tb;

  localparam int FRAC = 16;
  // Pipeline depth: the front register plus the divider's stages.
  localparam int LATENCY = FRAC + 2;
  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD = 300;
  localparam int RANDOM_PHASES = 9;
  localparam int PHASE_ITEMS = 150;
  localparam logic [FRAC:0] GRADE_ONE = {1'b1, {FRAC{1'b0}}};
  localparam logic [2:0] CFG_FIRST_UNUSED = fme_pkg::CFG_POINT_D + 3'd1;
  localparam longint X_MAX = 64'sh7FFF_FFFF;
  localparam longint X_MIN = -64'sh8000_0000;

  typedef struct packed {
    logic [FRAC:0] grade;
    logic [1:0]    region;
  } membership_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_sample_x = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [FRAC:0] out_grade;
  logic [1:0] out_region;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // The bench's own copy of the fuzzy set, updated whenever a register write
  // is accepted by the block.
  logic trap_mode;
  logic signed [31:0] pt_a, pt_b, pt_c, pt_d;

  // Samples waiting to be driven, and grades waiting to come back.
  logic signed [31:0] pending_x[$];
  membership_t expected_grades[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  int mismatches = 0;
  int cycle_count = 0;

  fuzzy_membership_evaluator #(.FRAC_BITS(FRAC)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_sample_x (in_sample_x),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_grade   (out_grade),
    .out_region  (out_region),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Grades one sample against the current set. All differences are taken in
  // 64 bits, so extreme breakpoints cannot wrap. The tests run in a fixed
  // order with no check that the breakpoints are sorted; an edge whose test
  // cannot hold is simply never reached.
  function automatic membership_t grade_of(logic signed [31:0] x);
    longint sx, a, b, c, d, right, num, den, q;
    membership_t r;
    sx = longint'(x);
    a = longint'(pt_a);
    b = longint'(pt_b);
    c = longint'(pt_c);
    d = longint'(pt_d);
    if (trap_mode) begin
      right = d;
    end else begin
      right = c;
    end
    num = 0;
    den = 0;
    r.grade = '0;
    r.region = fme_pkg::REG_OUTSIDE;
    if (sx <= a || sx >= right) begin
      r.region = fme_pkg::REG_OUTSIDE;
    end else if (sx <= b) begin
      // A sample sitting exactly on b lands here with a full grade.
      r.region = fme_pkg::REG_RISING;
      num = sx - a;
      den = b - a;
    end else if (trap_mode && sx <= c) begin
      r.region = fme_pkg::REG_PLATEAU;
      r.grade = GRADE_ONE;
    end else if (trap_mode) begin
      r.region = fme_pkg::REG_FALLING;
      num = d - sx;
      den = d - c;
    end else begin
      // A triangle falls straight from its peak; it has no plateau.
      r.region = fme_pkg::REG_FALLING;
      num = c - sx;
      den = c - b;
    end
    // A non-positive divisor or numerator leaves the grade at zero, and the
    // truncated quotient is clipped at one.
    if (num > 0 && den > 0) begin
      q = (num << FRAC) / den;
      if (q > GRADE_ONE) begin
        r.grade = GRADE_ONE;
      end else begin
        r.grade = q[FRAC:0];
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
  endtask

  // Writes one register through the configuration channel and mirrors the
  // write into the bench's copy. Indexes past the last register are ignored
  // by the block, so they leave the copy alone too.
  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      fme_pkg::CFG_SHAPE_MODE: trap_mode = data[0];
      fme_pkg::CFG_POINT_A:    pt_a = data;
      fme_pkg::CFG_POINT_B:    pt_b = data;
      fme_pkg::CFG_POINT_C:    pt_c = data;
      fme_pkg::CFG_POINT_D:    pt_d = data;
      default: ;
    endcase
  endtask

  // Loads a whole set. The shape register gets random upper bits so that the
  // block is seen to keep only bit zero. It returns on a falling edge, so the
  // caller can fill the sample queue without racing the driver.
  task automatic load_set(logic mode, logic [31:0] a, logic [31:0] b,
                          logic [31:0] c, logic [31:0] d);
    logic [31:0] word;
    word = $urandom;
    word[0] = mode;
    write_reg(fme_pkg::CFG_SHAPE_MODE, word);
    write_reg(fme_pkg::CFG_POINT_A, a);
    write_reg(fme_pkg::CFG_POINT_B, b);
    write_reg(fme_pkg::CFG_POINT_C, c);
    write_reg(fme_pkg::CFG_POINT_D, d);
    @(negedge clk);
  endtask

  // Waits on a falling edge until every queued sample has gone in and every
  // grade has come back.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_x.size() != 0 || in_valid || expected_grades.size() != 0);
  endtask

  // Driver: a word stays on the bus until it is taken. Once taken, the next
  // sample is offered at once unless the sender chooses to idle this cycle.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_sample_x <= '0;
    end else if (!in_valid || in_ready) begin
      if (pending_x.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_sample_x <= pending_x.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, plus a long hold-off whenever the stimulus
  // process asks for one. During the hold the block fills and must drop
  // in_ready without losing a word.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      holds_served <= 0;
    end else if (holds_served != hold_requests) begin
      holds_served <= holds_served + 1;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Scoreboard: the outgoing word is checked before any incoming sample is
  // graded, so the order within one edge is fixed.
  always @(posedge clk) begin : scoreboard
    membership_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_grades.size() == 0) begin
          report_mismatch("unexpected result word", 0, 32'(out_grade));
        end else begin
          want = expected_grades.pop_front();
          if (out_grade !== want.grade) begin
            report_mismatch("grade", 32'(want.grade), 32'(out_grade));
          end
          if (out_region !== want.region) begin
            report_mismatch("region", 32'(want.region), 32'(out_region));
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_grades.push_back(grade_of(in_sample_x));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("fuzzy_membership_evaluator regression: fail");
      $finish;
    end
  end

  initial begin
    longint pts[4];
    longint tmp, x64, lo, hi, off, u;
    int kind, sh, pick;

    trap_mode = fme_pkg::RST_SHAPE_MODE;
    pt_a = fme_pkg::RST_POINT_A;
    pt_b = fme_pkg::RST_POINT_B;
    pt_c = fme_pkg::RST_POINT_C;
    pt_d = fme_pkg::RST_POINT_D;
    send_idle_pct = 13;
    recv_idle_pct = 48;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // The reset set is the trapezoid 0, 1, 2, 3. Walk its feet, shoulders,
    // plateau and both extremes of the sample range without writing anything.
    pending_x.push_back(32'h0000_0000); pending_x.push_back(32'h0000_0001);
    pending_x.push_back(32'h0000_8000); pending_x.push_back(32'h0001_0000);
    pending_x.push_back(32'h0001_0001); pending_x.push_back(32'h0002_0000);
    pending_x.push_back(32'h0002_0001); pending_x.push_back(32'h0003_0000);
    pending_x.push_back(32'h7FFF_FFFF); pending_x.push_back(32'h8000_0000);
    wait_drained();

    // Triangle spanning the whole range: the most negative foot, a peak at
    // zero and the most positive right foot. It must never report a plateau.
    load_set(1'b0, 32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFFF, $urandom);
    pending_x.push_back(32'h8000_0000); pending_x.push_back(32'h8000_0001);
    pending_x.push_back(32'hFFFF_FFFF); pending_x.push_back(32'h0000_0000);
    pending_x.push_back(32'h0000_0001); pending_x.push_back(32'h7FFF_FFFE);
    pending_x.push_back(32'h7FFF_FFFF);
    wait_drained();

    // Breakpoints out of order: b lies left of a and d left of c.
    load_set(1'b1, 32'h0003_0000, 32'h0001_0000, 32'h0005_0000, 32'h0004_0000);
    pending_x.push_back(32'h0002_0000); pending_x.push_back(32'h0003_8000);
    pending_x.push_back(32'h0004_8000); pending_x.push_back(32'h0006_0000);
    wait_drained();

    // Trapezoid with vertical sides: both edges have zero width.
    load_set(1'b1, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 32'h0001_0000);
    pending_x.push_back(32'h0000_0001); pending_x.push_back(32'h0000_FFFF);
    pending_x.push_back(32'h0001_0000);
    wait_drained();

    // Indexes past the register list must be ignored.
    for (int k = 0; k < 3; k++) begin
      write_reg(CFG_FIRST_UNUSED + 3'(k), $urandom);
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      // Three idling regimes: mostly a slow receiver, then mostly a slow
      // sender, then neither.
      if (p < 3) begin
        send_idle_pct = 13;
        recv_idle_pct = 48;
      end else if (p < 6) begin
        send_idle_pct = 48;
        recv_idle_pct = 13;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      // Set shapes: the full range with its extremes as a and d, a compact sorted
      // set near zero, an unsorted set, or sorted points anywhere in range.
      if (p == 0) begin
        kind = 0;
      end else if (p % 4 == 3) begin
        kind = 2;
      end else if (p % 4 == 1) begin
        kind = 3;
      end else begin
        kind = 1;
      end
      case (kind)
        0: begin
          pts[0] = X_MIN;
          pts[1] = longint'(signed'($urandom));
          pts[2] = longint'(signed'($urandom));
          pts[3] = X_MAX;
        end
        1: begin
          pts[0] = longint'($urandom_range(0, 1 << 23)) - (1 << 22);
          for (int k = 1; k < 4; k++) begin
            if ($urandom_range(0, 7) == 0) begin
              pts[k] = pts[k - 1];
            end else begin
              pts[k] = pts[k - 1] + longint'($urandom_range(1, 1 << 18));
            end
          end
        end
        2: begin
          for (int k = 0; k < 4; k++) begin
            pts[k] = longint'($urandom_range(0, 1 << 21)) - (1 << 20);
          end
        end
        default: begin
          for (int k = 0; k < 4; k++) begin
            pts[k] = longint'(signed'($urandom));
          end
        end
      endcase
      if (kind != 2) begin
        for (int i = 0; i < 3; i++) begin
          for (int j = 0; j < 3 - i; j++) begin
            if (pts[j] > pts[j + 1]) begin
              tmp = pts[j];
              pts[j] = pts[j + 1];
              pts[j + 1] = tmp;
            end
          end
        end
      end
      load_set(p[0], pts[0][31:0], pts[1][31:0], pts[2][31:0], pts[3][31:0]);

      // With the sender running flat out, stall the receiver long enough for
      // the pipeline to fill and push back on the input.
      if (p == 6) begin
        hold_requests++;
      end

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        pick = $urandom_range(0, 9);
        lo = longint'(pt_a);
        if (trap_mode) begin
          hi = longint'(pt_d);
        end else begin
          hi = longint'(pt_c);
        end
        if (pick < 6) begin
          // Close to a breakpoint, at a random binary scale.
          case ($urandom_range(0, 3))
            0: x64 = longint'(pt_a);
            1: x64 = longint'(pt_b);
            2: x64 = longint'(pt_c);
            default: x64 = longint'(pt_d);
          endcase
          sh = $urandom_range(0, 20);
          off = longint'($urandom_range(0, 1 << sh));
          if ($urandom_range(0, 1) == 1) begin
            x64 = x64 + off;
          end else begin
            x64 = x64 - off;
          end
        end else if (pick < 8 && hi > lo) begin
          // Anywhere across the support.
          u = longint'($urandom);
          x64 = lo + ((((hi - lo) >> 2) * u) >> 30);
        end else begin
          x64 = longint'(signed'($urandom));
        end
        if (x64 > X_MAX) begin
          x64 = X_MAX;
        end
        if (x64 < X_MIN) begin
          x64 = X_MIN;
        end
        pending_x.push_back(x64[31:0]);
      end
      wait_drained();
    end

    // Allow any stray word time to surface before the verdict.
    repeat (2 * LATENCY) @(negedge clk);
    if (mismatches == 0 && expected_grades.size() == 0) begin
      $display("fuzzy_membership_evaluator regression: pass");
    end else begin
      $display("fuzzy_membership_evaluator regression: fail");
    end
    $finish;
  end

endmodule
